### rtl/vfcm_pkg.sv
// Shared types, constants and face tables of the voxel face-cull mesher.
// No dependencies; every other file imports this package.
package vfcm_pkg;

    localparam int COORD_W   = 2;
    localparam int POS_W     = 3;
    localparam int MAT_W     = 8;
    localparam int VNUM_W    = 16;
    localparam int FACE_W    = 3;
    localparam int STEP_W    = 3;
    localparam int NUM_FACES = 6;
    localparam int COORD_SPAN = 2 ** COORD_W;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_MESH  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Lookup step 0 reads the named cell, steps 1 to 6 read its neighbors.
    localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
    localparam logic [STEP_W-1:0] STEP_LAST   = 3'd6;

    localparam logic [1:0] CORNER_LAST = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0] dx;
        logic [POS_W-1:0] dy;
        logic [POS_W-1:0] dz;
    } dir_t;

    // Neighbor offsets in two's complement, face order -z, +z, +x, -x, +y, -y.
    localparam dir_t FACE_DIR [NUM_FACES] = '{
        '{3'd0, 3'd0, 3'd7},
        '{3'd0, 3'd0, 3'd1},
        '{3'd1, 3'd0, 3'd0},
        '{3'd7, 3'd0, 3'd0},
        '{3'd0, 3'd1, 3'd0},
        '{3'd0, 3'd7, 3'd0}
    };

    // Corner offsets packed as {x, y, z}.
    localparam logic [2:0] CORNER_XYZ [NUM_FACES][4] = '{
        '{3'b000, 3'b010, 3'b110, 3'b100},
        '{3'b001, 3'b011, 3'b111, 3'b101},
        '{3'b100, 3'b101, 3'b111, 3'b110},
        '{3'b000, 3'b001, 3'b011, 3'b010},
        '{3'b010, 3'b011, 3'b111, 3'b110},
        '{3'b000, 3'b001, 3'b101, 3'b100}
    };

    // Texture coordinates packed as {u, v}.
    localparam logic [1:0] CORNER_UV [NUM_FACES][4] = '{
        '{2'b11, 2'b10, 2'b00, 2'b01},
        '{2'b01, 2'b00, 2'b10, 2'b11},
        '{2'b11, 2'b01, 2'b00, 2'b10},
        '{2'b01, 2'b11, 2'b10, 2'b00},
        '{2'b01, 2'b00, 2'b10, 2'b11},
        '{2'b01, 2'b00, 2'b10, 2'b11}
    };

    // Bit f gives the winding of face f.
    localparam logic [NUM_FACES-1:0] FACE_WINDING = 6'b100110;

    typedef struct packed {
        logic              write_cell;
        logic              clear_count;
        logic              latch_cell;
        logic              issue_read;
        logic [STEP_W-1:0] read_step;
        logic              load_vertex;
    } dp_cmd_t;

    typedef struct packed {
        logic faces_left;
        logic out_free;
        logic final_vertex;
    } dp_status_t;

endpackage

### rtl/vfcm_cmd_if.sv
// Command channel: valid/ready handshake carrying one command word.
// Depends on vfcm_pkg for field widths.
interface vfcm_cmd_if
    import vfcm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
    logic [MAT_W-1:0]   material;

    modport source (output valid, action, cell_x, cell_y, cell_z, material, input ready);
    modport sink (input valid, action, cell_x, cell_y, cell_z, material, output ready);
endinterface

### rtl/vfcm_vtx_if.sv
// Vertex channel: valid/ready handshake carrying one vertex word.
// Depends on vfcm_pkg for field widths.
interface vfcm_vtx_if
    import vfcm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic              tex_u;
    logic              tex_v;
    logic [MAT_W-1:0]  layer;
    logic [VNUM_W-1:0] vertex_number;
    logic [FACE_W-1:0] face;
    logic              winding;
    logic              last;

    modport source (
        output valid, pos_x, pos_y, pos_z, tex_u, tex_v, layer, vertex_number, face,
               winding, last,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, tex_u, tex_v, layer, vertex_number, face,
               winding, last,
        output ready
    );
endinterface

### rtl/vfcm_ctrl.sv
// Sequencing state machine of the mesher: command decode, neighbor lookups, vertex output.
// Depends on vfcm_pkg; drives vfcm_datapath through dp_cmd_t.
module vfcm_ctrl
    import vfcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  logic [1:0] cmd_action,
    output logic       cmd_ready,
    input  dp_status_t status,
    output dp_cmd_t    dp_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_EMIT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              accept;

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dp_cmd     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_action)
                        ACT_WRITE: dp_cmd.write_cell = 1'b1;
                        ACT_CLEAR: dp_cmd.clear_count = 1'b1;
                        ACT_MESH:
                        begin
                            dp_cmd.latch_cell = 1'b1;
                            step_next         = STEP_CENTER;
                            state_next        = S_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                dp_cmd.issue_read = 1'b1;
                dp_cmd.read_step  = step_reg;
                step_next         = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!status.faces_left)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    dp_cmd.load_vertex = 1'b1;
                    if (status.final_vertex)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= STEP_CENTER;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

### rtl/vfcm_datapath.sv
// Datapath of the mesher: voxel memory with valid bits, face mask, counters, output register.
// Depends on vfcm_pkg; commanded by vfcm_ctrl.
module vfcm_datapath
    import vfcm_pkg::*;
#(
    parameter int GRID_SIZE = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            dp_cmd,
    output dp_status_t         status,
    input  logic [COORD_W-1:0] in_x,
    input  logic [COORD_W-1:0] in_y,
    input  logic [COORD_W-1:0] in_z,
    input  logic [MAT_W-1:0]   in_material,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [POS_W-1:0]   pos_x,
    output logic [POS_W-1:0]   pos_y,
    output logic [POS_W-1:0]   pos_z,
    output logic               tex_u,
    output logic               tex_v,
    output logic [MAT_W-1:0]   layer,
    output logic [VNUM_W-1:0]  vertex_number,
    output logic [FACE_W-1:0]  face,
    output logic               winding,
    output logic               last
);

    // Coordinates are two bits wide, so only cells below four on each axis are reachable.
    localparam int DIM   = (GRID_SIZE < COORD_SPAN) ? GRID_SIZE : COORD_SPAN;
    localparam int DEPTH = DIM * DIM * DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [POS_W-1:0] DIM_P = POS_W'(DIM);
    localparam logic [AW-1:0] ROW_STRIDE   = AW'(DIM);
    localparam logic [AW-1:0] PLANE_STRIDE = AW'(DIM * DIM);

    logic [MAT_W-1:0]     mem [DEPTH];
    logic [DEPTH-1:0]     written_reg;
    logic [COORD_W-1:0]   cx_reg, cy_reg, cz_reg;
    logic [MAT_W-1:0]     center_reg;
    logic [MAT_W-1:0]     rd_data_reg;
    logic                 rd_hit_reg;
    logic                 rd_pend_reg;
    logic [STEP_W-1:0]    rd_tag_reg;
    logic [NUM_FACES-1:0] mask_reg;
    logic [1:0]           corner_reg;
    logic [VNUM_W-1:0]    count_reg;
    logic                 out_valid_reg;

    logic [POS_W-1:0]     rx, ry, rz;
    logic [POS_W-1:0]     wx, wy, wz;
    logic                 r_in_grid, w_in_grid;
    logic [AW-1:0]        ridx, widx;
    logic [FACE_W-1:0]    look_face, cap_face, cur_face;
    dir_t                 dir;
    logic [MAT_W-1:0]     rd_value;
    logic [NUM_FACES-1:0] low_bit, rest_mask;
    logic [2:0]           cxyz;
    logic [1:0]           cuv;
    logic                 out_free;

    assign look_face = FACE_W'(dp_cmd.read_step - 1'b1);
    assign cap_face  = FACE_W'(rd_tag_reg - 1'b1);

    always_comb
    begin
        dir = FACE_DIR[look_face];
        rx  = {1'b0, cx_reg};
        ry  = {1'b0, cy_reg};
        rz  = {1'b0, cz_reg};
        if (dp_cmd.read_step != STEP_CENTER)
        begin
            rx = rx + dir.dx;
            ry = ry + dir.dy;
            rz = rz + dir.dz;
        end
    end

    assign wx = {1'b0, in_x};
    assign wy = {1'b0, in_y};
    assign wz = {1'b0, in_z};

    assign r_in_grid = (rx < DIM_P) && (ry < DIM_P) && (rz < DIM_P);
    assign w_in_grid = (wx < DIM_P) && (wy < DIM_P) && (wz < DIM_P);

    assign ridx = AW'(rx) + AW'(ry) * ROW_STRIDE + AW'(rz) * PLANE_STRIDE;
    assign widx = AW'(wx) + AW'(wy) * ROW_STRIDE + AW'(wz) * PLANE_STRIDE;

    assign rd_value = rd_hit_reg ? rd_data_reg : '0;

    always_comb
    begin
        cur_face = '0;
        for (int f = NUM_FACES - 1; f >= 0; f--)
        begin
            if (mask_reg[f])
            begin
                cur_face = FACE_W'(f);
            end
        end
    end

    assign low_bit   = mask_reg & (~mask_reg + 1'b1);
    assign rest_mask = mask_reg & ~low_bit;
    assign cxyz      = CORNER_XYZ[cur_face][corner_reg];
    assign cuv       = CORNER_UV[cur_face][corner_reg];
    assign out_free  = !out_valid_reg || out_ready;

    assign status.faces_left   = |mask_reg;
    assign status.out_free     = out_free;
    assign status.final_vertex = (corner_reg == CORNER_LAST) && (rest_mask == '0);

    always_ff @(posedge clk)
    begin
        if (dp_cmd.write_cell && w_in_grid)
        begin
            mem[widx] <= in_material;
        end
        if (dp_cmd.issue_read)
        begin
            rd_data_reg <= mem[ridx];
        end
        if (dp_cmd.latch_cell)
        begin
            cx_reg <= in_x;
            cy_reg <= in_y;
            cz_reg <= in_z;
        end
        if (rd_pend_reg && (rd_tag_reg == STEP_CENTER))
        begin
            center_reg <= rd_value;
        end
        if (dp_cmd.load_vertex)
        begin
            pos_x         <= {1'b0, cx_reg} + {2'b00, cxyz[2]};
            pos_y         <= {1'b0, cy_reg} + {2'b00, cxyz[1]};
            pos_z         <= {1'b0, cz_reg} + {2'b00, cxyz[0]};
            tex_u         <= cuv[1];
            tex_v         <= cuv[0];
            layer         <= center_reg - 1'b1;
            vertex_number <= count_reg;
            face          <= cur_face;
            winding       <= FACE_WINDING[cur_face];
            last          <= status.final_vertex;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            rd_hit_reg    <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_tag_reg    <= STEP_CENTER;
            mask_reg      <= '0;
            corner_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.write_cell && w_in_grid)
            begin
                written_reg[widx] <= 1'b1;
            end
            rd_pend_reg <= dp_cmd.issue_read;
            if (dp_cmd.issue_read)
            begin
                rd_tag_reg <= dp_cmd.read_step;
                rd_hit_reg <= r_in_grid && written_reg[ridx];
            end
            if (dp_cmd.latch_cell)
            begin
                mask_reg   <= '0;
                corner_reg <= '0;
            end
            else if (rd_pend_reg && (rd_tag_reg != STEP_CENTER))
            begin
                mask_reg[cap_face] <= (center_reg != '0) && (rd_value == '0);
            end
            else if (dp_cmd.load_vertex)
            begin
                corner_reg <= corner_reg + 1'b1;
                if (corner_reg == CORNER_LAST)
                begin
                    mask_reg <= rest_mask;
                end
            end
            if (dp_cmd.clear_count)
            begin
                count_reg <= '0;
            end
            else if (dp_cmd.load_vertex)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (dp_cmd.load_vertex)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/voxel_face_cull_mesher_top.sv
// Top level of the voxel face-cull mesher: controller plus datapath behind two channels.
// Depends on vfcm_pkg, vfcm_cmd_if, vfcm_vtx_if, vfcm_ctrl and vfcm_datapath.
//
// The cmd channel takes one word per command: write a cell, mesh a cell or clear the
// vertex counter. The vtx channel returns one word per vertex, four per exposed face,
// in face order -z, +z, +x, -x, +y, -y, with last set on the final vertex of a mesh.
// After a write or a clear the block stays ready, so the next word can be taken in the
// cycle after. A mesh command reads the cell and then its six neighbors through the
// single read port of the voxel memory, waits in a drain state for the last read to
// return, and then loads one vertex per cycle into the output register while that
// register is free. When no face is exposed, the block returns to idle with no vertex.
// The command channel is not ready again until the last vertex has been loaded into the
// output register.
// Reset clears the cell valid bits, so every cell reads as empty, zeroes the vertex
// counter and drops both channels to idle. When the receiver stalls, the output
// register holds its word and the vertex sequence pauses without loss.
module voxel_face_cull_mesher_top
    import vfcm_pkg::*;
#(
    parameter int GRID_SIZE = 4
)
(
    input logic        clk,
    input logic        rst_n,
    vfcm_cmd_if.sink   cmd,
    vfcm_vtx_if.source vtx
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    vfcm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_action (cmd.action),
        .cmd_ready  (cmd.ready),
        .status     (dp_status),
        .dp_cmd     (dp_cmd)
    );

    vfcm_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .status        (dp_status),
        .in_x          (cmd.cell_x),
        .in_y          (cmd.cell_y),
        .in_z          (cmd.cell_z),
        .in_material   (cmd.material),
        .out_ready     (vtx.ready),
        .out_valid     (vtx.valid),
        .pos_x         (vtx.pos_x),
        .pos_y         (vtx.pos_y),
        .pos_z         (vtx.pos_z),
        .tex_u         (vtx.tex_u),
        .tex_v         (vtx.tex_v),
        .layer         (vtx.layer),
        .vertex_number (vtx.vertex_number),
        .face          (vtx.face),
        .winding       (vtx.winding),
        .last          (vtx.last)
    );

endmodule

### rtl/vfcm_checker.sv
// Port-level checker for the voxel face-cull mesher and its bind to the top level.
// Depends on vfcm_pkg and voxel_face_cull_mesher_top.
module vfcm_checker
    import vfcm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic [1:0]        cmd_action,
    input logic              vtx_valid,
    input logic              vtx_ready,
    input logic [VNUM_W-1:0] vtx_vertex_number,
    input logic [FACE_W-1:0] vtx_face,
    input logic              vtx_last
);

    logic cmd_take;
    logic vtx_take;

    assign cmd_take = cmd_valid && cmd_ready;
    assign vtx_take = vtx_valid && vtx_ready;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_valid && !vtx_ready |=> vtx_valid && $stable(vtx_vertex_number)
            && $stable(vtx_face) && $stable(vtx_last))
        else $error("Vertex word changed while stalled.");

    a_mesh_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && (cmd_action == ACT_MESH) |=> !cmd_ready)
        else $error("Command taken while a mesh lookup is in progress.");

    a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && (cmd_action != ACT_MESH) |=> cmd_ready)
        else $error("Block not ready after a write or clear command.");

    a_vertex_run: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_take && !vtx_last |=> vtx_valid
            && (vtx_vertex_number == $past(vtx_vertex_number) + 1'b1))
        else $error("Vertex sequence broken before the last vertex.");

endmodule

bind voxel_face_cull_mesher_top vfcm_checker u_vfcm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .cmd_action        (cmd.action),
    .vtx_valid         (vtx.valid),
    .vtx_ready         (vtx.ready),
    .vtx_vertex_number (vtx.vertex_number),
    .vtx_face          (vtx.face),
    .vtx_last          (vtx.last)
);
